// ===== sv/chr_pkg.sv =====
// ----------------------------------------------------------------------------
// Consistent hash ring package
// Shared sizes, operation and status codes, and the cell control structs.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int RING_ENTRIES = 16;
  localparam int IDENT_BITS   = 8;
  localparam int COUNT_W      = $clog2(RING_ENTRIES + 1);

  localparam int HASH_W   = 32;
  localparam int NODE_W   = 8;
  localparam int USED_W   = 5;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2
  } chr_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } chr_status_e;

  // Broadcast to every cell for the current transfer.
  typedef struct packed {
    logic                  add_en;
    logic                  rem_en;
    logic [HASH_W-1:0]     node_hash;
    logic [IDENT_BITS-1:0] node_ident;
    logic [HASH_W-1:0]     lookup_key;
  } chr_cmd_t;

  // Flags handed from one cell to its right neighbor.
  typedef struct packed {
    logic le;    // occupied entry with hash <= node hash
    logic seen;  // identifier match at this cell or any cell to the left
    logic ge;    // occupied entry with hash >= key hash
  } chr_link_t;

endpackage

// ===== sv/consistent_hash_ring.sv =====
// Consistent hash ring: a row of RING_ENTRIES cells keeps the ring sorted by
// hash. Every cell compares its entry against the incoming transfer at once,
// so an add, remove or lookup is handled by one compare and shift across the
// cell row, and the block takes one transfer per cycle while the master side
// takes its results; the result is registered and appears on the master side
// the cycle after acceptance. The output register decouples the two sides: a
// new transfer is accepted whenever the result register is empty or is being
// taken in the same cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// Consistent hash ring top level
// Cell row, lookup selection, entry count and registered result.
// ----------------------------------------------------------------------------
module consistent_hash_ring import chr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // func
  input  logic [FUNC_W-1:0]        s_axis_tuser,
  // node_hash[31:0], node_ident[39:32], lookup_key[71:40]
  input  logic [71:0]              s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // status
  output logic [STATUS_W-1:0]      m_axis_tuser,
  // primary_node[7:0], primary_valid[8], secondary_node[16:9],
  // secondary_valid[17], entries_used[22:18], zero fill[23]
  output logic [23:0]              m_axis_tdata
);

  localparam int N = RING_ENTRIES;

  logic                  accept;
  chr_func_e             func;
  chr_cmd_t              cmd;
  logic [COUNT_W-1:0]    total_q, total_d;
  logic                  full, empty, found;

  logic [N-1:0]          occ, occ_next, first, prim_oh, sec_oh;
  logic                  wrap_sec;
  logic [HASH_W-1:0]     hash_w [N];
  logic [IDENT_BITS-1:0] node_w [N];
  chr_link_t             link_w [N];
  logic [IDENT_BITS-1:0] prim_node, sec_node;

  chr_status_e           status_d, status_q;
  logic [NODE_W-1:0]     pn_d, sn_d, pn_q, sn_q;
  logic                  pv_d, sv_d, pv_q, sv_q;
  logic [USED_W-1:0]     used_q;
  logic                  out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func          = chr_func_e'(s_axis_tuser);

  assign full  = (total_q == COUNT_W'(N));
  assign empty = (total_q == '0);

  always_comb begin
    cmd.add_en     = accept && (func == FN_ADD) && !full;
    cmd.rem_en     = accept && (func == FN_REMOVE);
    cmd.node_hash  = s_axis_tdata[31:0];
    cmd.node_ident = IDENT_BITS'(s_axis_tdata[39:32]);
    cmd.lookup_key = s_axis_tdata[71:40];
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [HASH_W-1:0]     lh, rh;
    logic [IDENT_BITS-1:0] ln, rn;
    chr_link_t             ll;

    assign occ[i] = (COUNT_W'(i) < total_q);

    if (i == 0) begin : g_head
      assign lh = hash_w[0];
      assign ln = node_w[0];
      // a new entry lands in cell 0 when no entry has a lower or equal hash
      assign ll = '{le: 1'b1, seen: 1'b0, ge: 1'b0};
    end else begin : g_body
      assign lh = hash_w[i-1];
      assign ln = node_w[i-1];
      assign ll = link_w[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rh          = hash_w[i];
      assign rn          = node_w[i];
      assign occ_next[i] = 1'b0;
    end else begin : g_mid
      assign rh          = hash_w[i+1];
      assign rn          = node_w[i+1];
      assign occ_next[i] = occ[i+1];
    end

    chr_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .left_hash_i  (lh),
      .left_node_i  (ln),
      .left_link_i  (ll),
      .right_hash_i (rh),
      .right_node_i (rn),
      .hash_o       (hash_w[i]),
      .node_o       (node_w[i]),
      .link_o       (link_w[i]),
      .first_o      (first[i])
    );
  end

  assign found = link_w[N-1].seen;

  // Wrap to entry 0 when no entry reaches the key; secondary follows primary.
  always_comb begin
    prim_oh   = (|first) ? first : N'(1);
    wrap_sec  = |(prim_oh & ~occ_next);
    sec_oh    = ((prim_oh << 1) & occ) | (wrap_sec ? N'(1) : '0);
    prim_node = '0;
    sec_node  = '0;
    for (int i = 0; i < N; i++) begin
      prim_node = prim_node | (prim_oh[i] ? node_w[i] : '0);
      sec_node  = sec_node  | (sec_oh[i]  ? node_w[i] : '0);
    end
  end

  always_comb begin
    total_d  = total_q;
    status_d = ST_OK;
    pn_d     = '0;
    pv_d     = 1'b0;
    sn_d     = '0;
    sv_d     = 1'b0;
    case (func)
      FN_ADD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          total_d = total_q + COUNT_W'(1);
        end
      end
      FN_REMOVE: begin
        if (found) begin
          total_d = total_q - COUNT_W'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      FN_LOOKUP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          pn_d = NODE_W'(prim_node);
          pv_d = 1'b1;
          if (total_q >= COUNT_W'(2)) begin
            sn_d = NODE_W'(sec_node);
            sv_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pn_q     <= pn_d;
      pv_q     <= pv_d;
      sn_q     <= sn_d;
      sv_q     <= sv_d;
      used_q   <= USED_W'(total_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {1'b0, used_q, sv_q, sn_q, pv_q, pn_q};

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= COUNT_W'(N))
    else $error("entry count exceeds ring size");

  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == FN_ADD) && !full |=> total_q == $past(total_q) + COUNT_W'(1))
    else $error("add did not grow the ring");

  a_first_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first))
    else $error("more than one lookup hit");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted transfer left no result");

  a_lookup_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == FN_LOOKUP) && !empty |=> pv_q && (status_q == ST_OK))
    else $error("lookup on a populated ring found no primary");

endmodule

// ===== sv/chr_cell.sv =====
// ----------------------------------------------------------------------------
// Consistent hash ring cell
// Holds one ring entry, compares it against the current command and shifts
// in from its left neighbor on insert or from its right neighbor on removal.
// ----------------------------------------------------------------------------
module chr_cell import chr_pkg::*; (
  input  logic                  clk_i,
  input  chr_cmd_t              cmd_i,
  input  logic                  occ_i,
  input  logic [HASH_W-1:0]     left_hash_i,
  input  logic [IDENT_BITS-1:0] left_node_i,
  input  chr_link_t             left_link_i,
  input  logic [HASH_W-1:0]     right_hash_i,
  input  logic [IDENT_BITS-1:0] right_node_i,
  output logic [HASH_W-1:0]     hash_o,
  output logic [IDENT_BITS-1:0] node_o,
  output chr_link_t             link_o,
  output logic                  first_o
);

  logic [HASH_W-1:0]     hash_q;
  logic [IDENT_BITS-1:0] node_q;
  logic [HASH_W-1:0]     hash_d;
  logic [IDENT_BITS-1:0] node_d;

  always_comb begin
    link_o.le   = occ_i && (hash_q <= cmd_i.node_hash);
    link_o.seen = left_link_i.seen || (occ_i && (node_q == cmd_i.node_ident));
    link_o.ge   = occ_i && (hash_q >= cmd_i.lookup_key);
    first_o     = link_o.ge && !left_link_i.ge;
  end

  always_comb begin
    hash_d = hash_q;
    node_d = node_q;
    if (cmd_i.add_en && !link_o.le) begin
      // insert point sits right after the last entry with hash <= new hash
      if (left_link_i.le) begin
        hash_d = cmd_i.node_hash;
        node_d = cmd_i.node_ident;
      end else begin
        hash_d = left_hash_i;
        node_d = left_node_i;
      end
    end else if (cmd_i.rem_en && link_o.seen) begin
      // close the gap from the first match onward
      hash_d = right_hash_i;
      node_d = right_node_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    node_q <= node_d;
  end

  assign hash_o = hash_q;
  assign node_o = node_q;

endmodule
